// ===== rtl/lcfb_pkg.sv =====
// Shared types, constants and the CRC-8 step for the lamp colour frame builder.
// Used by every module of the block; depends on nothing else.
package lcfb_pkg;

  localparam int NUM_LAMPS   = 10;
  localparam int HDR_LEN     = 4;
  localparam int PAYLOAD_LEN = 3 * NUM_LAMPS;
  localparam int FRAME_LEN   = HDR_LEN + PAYLOAD_LEN + 1;
  localparam int LAMP_W      = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
  localparam int POS_W       = $clog2(FRAME_LEN);
  localparam int COLOR_W     = 24;
  localparam int BYTE_W      = 8;
  localparam int QDEPTH      = 2;
  localparam int Q_AW        = $clog2(QDEPTH);
  localparam int CFG_IDX_W   = 1;

  localparam logic [BYTE_W-1:0] PREAMBLE      = 8'h40;
  localparam logic [BYTE_W-1:0] SRC_ADDR_RST  = 8'hFE;
  localparam logic [BYTE_W-1:0] CTRL_ADDR_RST = 8'h10;
  localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h07;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_ADDR = 1'b1;

  typedef struct packed {
    logic               clear;
    logic               set_en;
    logic [LAMP_W-1:0]  lamp_idx;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/lamp_color_frame_builder_top.sv =====
// Top level of the lamp colour frame builder.
// Depends on lcfb_pkg, lcfb_front, lcfb_cmd_fifo and lcfb_back.
//
//   Channel   Direction  Handshake              Payload
//   in_       slave      in_tvalid/in_tready    func, lamp_number, color_value
//   out_      master     out_tvalid/out_tready  frame_byte, last_byte on tlast
//   cfg_      write      cfg_wr_en              source/controller address
//
// Each command produces a frame of 3 * NUM_LAMPS + 5 bytes (35 bytes), one byte per cycle
// while the output is not stalled; between frames the sequencer returns to idle to
// pull the next command from the two-entry queue and apply it to the colours.
// Reset is synchronous and active low; it clears all lamp colours at once and
// restores the default addresses. Output stalls hold the frame sequencer while
// the queue keeps taking input transfers until it is full.
module lamp_color_frame_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // func [0], lamp_number [4:1], color_value [28:5], zero [31:29]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // frame_byte [7:0]
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [lcfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_wdata
);

  lcfb_pkg::cmd_t push_data;
  lcfb_pkg::cmd_t pop_data;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;

  lcfb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .func        (in_tdata[0]),
    .lamp_number (in_tdata[4:1]),
    .color_value (in_tdata[28:5]),
    .q_push      (q_push),
    .q_data      (push_data),
    .q_full      (q_full)
  );

  lcfb_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  lcfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .frame_byte (out_tdata),
    .last_byte  (out_tlast)
  );

endmodule

// ===== rtl/lcfb_cmd_fifo.sv =====
// Short command queue between the front and the back of the frame builder.
// Depends on lcfb_pkg for the command type and the queue depth.
module lcfb_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcfb_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lcfb_pkg::cmd_t pop_data
);

  lcfb_pkg::cmd_t             mem_r [lcfb_pkg::QDEPTH];
  logic [lcfb_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lcfb_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lcfb_pkg::Q_AW:0]    count_r, count_nxt;

  assign full      = (count_r == (lcfb_pkg::Q_AW+1)'(lcfb_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("command queue written while full");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (lcfb_pkg::Q_AW+1)'(lcfb_pkg::QDEPTH))
    else $error("command queue count out of range");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("command queue read while empty");
`endif

endmodule

// ===== rtl/lcfb_front.sv =====
// Input side of the frame builder: takes transfers and turns them into commands.
// Depends on lcfb_pkg and feeds lcfb_cmd_fifo.
module lcfb_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        func,
  input  logic [3:0]                  lamp_number,
  input  logic [lcfb_pkg::COLOR_W-1:0] color_value,
  output logic                        q_push,
  output lcfb_pkg::cmd_t              q_data,
  input  logic                        q_full
);

  logic [31:0] lamp_ext;
  logic [31:0] lamp_off;
  logic        in_range;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  assign lamp_ext = {28'd0, lamp_number};
  assign lamp_off = lamp_ext - 32'd1;
  assign in_range = (lamp_number != 4'd0) && (lamp_ext <= 32'(lcfb_pkg::NUM_LAMPS));

  always_comb begin
    q_data.clear    = func;
    q_data.set_en   = !func && in_range;
    q_data.lamp_idx = lamp_off[lcfb_pkg::LAMP_W-1:0];
    q_data.color    = color_value;
  end

`ifndef ASSERT_OFF
  a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.set_en |-> 32'(q_data.lamp_idx) < 32'(lcfb_pkg::NUM_LAMPS))
    else $error("lamp index beyond lamp count");
  a_set_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !(q_data.set_en && q_data.clear))
    else $error("command both sets and clears");
  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_tready)
    else $error("command pushed without ready");
`endif

endmodule

// ===== rtl/lcfb_back.sv =====
// Back end of the frame builder: holds lamp colours and address registers,
// applies queued commands and streams each frame with its CRC. Depends on lcfb_pkg.
module lcfb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lcfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcfb_pkg::BYTE_W-1:0]       cfg_wdata,
  input  logic                              q_valid,
  input  lcfb_pkg::cmd_t                    q_data,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lcfb_pkg::BYTE_W-1:0]       frame_byte,
  output logic                              last_byte
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  localparam logic [lcfb_pkg::POS_W-1:0]  LAST_POS  = lcfb_pkg::POS_W'(lcfb_pkg::FRAME_LEN - 1);
  localparam logic [lcfb_pkg::LAMP_W-1:0] LAMP_LAST = lcfb_pkg::LAMP_W'(lcfb_pkg::NUM_LAMPS - 1);
  localparam logic [lcfb_pkg::BYTE_W-1:0] LEN_BYTE  = lcfb_pkg::BYTE_W'(lcfb_pkg::PAYLOAD_LEN);

  logic [0:0]                        state_r;
  logic [lcfb_pkg::COLOR_W-1:0]      colors_r [lcfb_pkg::NUM_LAMPS];
  logic [lcfb_pkg::BYTE_W-1:0]       src_addr_r;
  logic [lcfb_pkg::BYTE_W-1:0]       ctrl_addr_r;
  logic [lcfb_pkg::POS_W-1:0]        pos_r;
  logic [lcfb_pkg::LAMP_W-1:0]       lamp_r;
  logic [1:0]                        comp_r;
  logic [lcfb_pkg::BYTE_W-1:0]       crc_r;
  logic                              out_valid_r;
  logic [lcfb_pkg::BYTE_W-1:0]       out_data_r;
  logic                              out_last_r;

  logic                              load;
  logic                              is_last;
  logic                              is_color;
  logic [lcfb_pkg::COLOR_W-1:0]      cur_color;
  logic [lcfb_pkg::BYTE_W-1:0]       color_byte;
  logic [lcfb_pkg::BYTE_W-1:0]       byte_nxt;

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign load       = (state_r == ST_RUN) && (!out_valid_r || out_tready);
  assign is_last    = (pos_r == LAST_POS);
  assign is_color   = (pos_r >= lcfb_pkg::POS_W'(lcfb_pkg::HDR_LEN)) && !is_last;
  assign cur_color  = colors_r[lamp_r];

  assign out_tvalid = out_valid_r;
  assign frame_byte = out_data_r;
  assign last_byte  = out_last_r;

  always_comb begin
    case (comp_r)
      2'd0:    color_byte = cur_color[23:16];
      2'd1:    color_byte = cur_color[15:8];
      default: color_byte = cur_color[7:0];
    endcase
  end

  always_comb begin
    if (pos_r == lcfb_pkg::POS_W'(0)) begin
      byte_nxt = lcfb_pkg::PREAMBLE;
    end else if (pos_r == lcfb_pkg::POS_W'(1)) begin
      byte_nxt = src_addr_r;
    end else if (pos_r == lcfb_pkg::POS_W'(2)) begin
      byte_nxt = ctrl_addr_r;
    end else if (pos_r == lcfb_pkg::POS_W'(3)) begin
      byte_nxt = LEN_BYTE;
    end else if (is_last) begin
      byte_nxt = crc_r;
    end else begin
      byte_nxt = color_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r  <= lcfb_pkg::SRC_ADDR_RST;
      ctrl_addr_r <= lcfb_pkg::CTRL_ADDR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lcfb_pkg::REG_SRC_ADDR:  src_addr_r  <= cfg_wdata;
        lcfb_pkg::REG_CTRL_ADDR: ctrl_addr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lcfb_pkg::NUM_LAMPS; i++) begin
        colors_r[i] <= '0;
      end
    end else if (q_pop) begin
      if (q_data.clear) begin
        for (int i = 0; i < lcfb_pkg::NUM_LAMPS; i++) begin
          colors_r[i] <= '0;
        end
      end else if (q_data.set_en) begin
        colors_r[q_data.lamp_idx] <= q_data.color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      lamp_r      <= '0;
      comp_r      <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            state_r <= ST_RUN;
            pos_r   <= '0;
            lamp_r  <= '0;
            comp_r  <= '0;
            crc_r   <= '0;
          end
        end
        ST_RUN: begin
          if (load) begin
            pos_r <= pos_r + 1'b1;
            if (is_color) begin
              crc_r <= lcfb_pkg::crc8_step(crc_r, color_byte);
              if (comp_r == 2'd2) begin
                comp_r <= '0;
                if (lamp_r != LAMP_LAST) begin
                  lamp_r <= lamp_r + 1'b1;
                end
              end else begin
                comp_r <= comp_r + 1'b1;
              end
            end
            if (is_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= byte_nxt;
      out_last_r <= is_last;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (pos_r <= LAST_POS))
    else $error("frame position beyond frame length");
  a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r != 2'd3)
    else $error("colour component counter out of range");
  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    load && is_last |=> out_valid_r && out_last_r && (state_r == ST_IDLE))
    else $error("CRC byte not flagged as last");
  a_pop_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_RUN) && (pos_r == '0) && (crc_r == '0))
    else $error("frame did not restart after command");
`endif

endmodule

// ===== tb/sv/tb_lamp_color_frame_builder_top.sv =====
// Self-checking testbench for lamp_color_frame_builder_top: directed and random lamp commands,
// with the expected frame bytes and CRC-8 worked out alongside and compared on every transfer.
// Depends on lcfb_pkg and the block's RTL only.
module tb_lamp_color_frame_builder_top;
  import lcfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AT_BYTE   = 100;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic       func;
    logic [3:0] lamp;
    logic [23:0] color;
  } lamp_cmd_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // func [0], lamp_number [4:1], color_value [28:5], zero [31:29]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // frame_byte [7:0]
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  lamp_cmd_t   pending_cmds[$];
  frame_byte_t frame_q[$];
  lamp_cmd_t   cur_cmd;
  logic [23:0] lamp_shadow[NUM_LAMPS];
  logic [7:0]  src_addr_shadow;
  logic [7:0]  ctrl_addr_shadow;
  bit          quiet = 1'b0;
  bit          hold_done = 1'b0;
  int          send_gap = 0;
  int          ready_gap = 0;
  int          hold_left = 0;
  int          bytes_seen = 0;
  int          errors = 0;
  int          stall_cycles = 0;

  lamp_color_frame_builder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  task automatic push_frame_byte(logic [7:0] data, logic last);
    frame_byte_t fb;
    fb.data = data;
    fb.last = last;
    frame_q.insert(frame_q.size(), fb);
  endtask

  // Applies one command to the colour shadow and queues the whole frame it produces.
  task automatic build_frame(lamp_cmd_t cmd);
    logic [7:0] crc;
    logic [7:0] colour_byte;
    crc = 8'h00;
    if (cmd.func) begin
      for (int i = 0; i < NUM_LAMPS; i++) lamp_shadow[i] = '0;
    end else if (cmd.lamp >= 1 && cmd.lamp <= NUM_LAMPS) begin
      lamp_shadow[cmd.lamp - 1] = cmd.color;
    end
    push_frame_byte(PREAMBLE, 1'b0);
    push_frame_byte(src_addr_shadow, 1'b0);
    push_frame_byte(ctrl_addr_shadow, 1'b0);
    push_frame_byte(8'(PAYLOAD_LEN), 1'b0);
    for (int i = 0; i < NUM_LAMPS; i++) begin
      for (int j = 2; j >= 0; j--) begin
        colour_byte = lamp_shadow[i][j*8 +: 8];
        crc = crc8_next(crc, colour_byte);
        push_frame_byte(colour_byte, 1'b0);
      end
    end
    push_frame_byte(crc, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      for (int i = 0; i < NUM_LAMPS; i++) lamp_shadow[i] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        build_frame(cur_cmd);
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 8);
          in_tvalid <= 1'b0;
        end else begin
          cur_cmd = pending_cmds.pop_front();
          in_tdata <= {3'b000, cur_cmd.color, cur_cmd.lamp, cur_cmd.func};
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, got byte %02h last %0b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = frame_q.pop_front();
          if (out_tdata !== want.data) begin
            errors++;
            $display("%0t: frame byte mismatch, expected %02h, got %02h",
                     $time, want.data, out_tdata);
          end
          if (out_tlast !== want.last) begin
            errors++;
            $display("%0t: last flag mismatch, expected %0b, got %0b",
                     $time, want.last, out_tlast);
          end
        end
        bytes_seen++;
        if (bytes_seen == HOLD_AT_BYTE && !hold_done) begin
          hold_left = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        ready_gap = $urandom_range(0, 8);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_SRC_ADDR) begin
      src_addr_shadow = value;
    end else begin
      ctrl_addr_shadow = value;
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_cmd(logic func, logic [3:0] lamp, logic [23:0] color);
    lamp_cmd_t cmd;
    cmd.func  = func;
    cmd.lamp  = lamp;
    cmd.color = color;
    pending_cmds.insert(pending_cmds.size(), cmd);
  endtask

  task automatic queue_random(int count);
    logic [3:0]  lamp;
    logic [23:0] color;
    for (int n = 0; n < count; n++) begin
      lamp  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, NUM_LAMPS));
      case ($urandom_range(0, 9))
        0:       color = 24'h000000;
        1:       color = 24'hFFFFFF;
        default: color = 24'($urandom);
      endcase
      queue_cmd($urandom_range(0, 7) == 0, lamp, color);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() > 0 || in_tvalid || frame_q.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    src_addr_shadow  = SRC_ADDR_RST;
    ctrl_addr_shadow = CTRL_ADDR_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the addresses left at their reset values.
    @(negedge clk);
    queue_cmd(1'b0, 4'd1, 24'hFFFFFF);
    queue_cmd(1'b0, 4'(NUM_LAMPS), 24'hFFFFFF);
    queue_cmd(1'b0, 4'd0, 24'h123456);
    queue_cmd(1'b0, 4'(NUM_LAMPS + 1), 24'hABCDEF);
    queue_cmd(1'b0, 4'd15, 24'hFFFFFF);
    queue_cmd(1'b0, 4'd5, 24'hA5A5A5);
    queue_cmd(1'b0, 4'd6, 24'h5A5A5A);
    queue_cmd(1'b0, 4'd2, 24'hFF0000);
    queue_cmd(1'b0, 4'd3, 24'h00FF00);
    queue_cmd(1'b0, 4'd4, 24'h0000FF);
    queue_cmd(1'b0, 4'd1, 24'h000000);
    queue_cmd(1'b1, 4'd15, 24'hFFFFFF);
    queue_cmd(1'b1, 4'd0, 24'h000000);
    for (int i = 1; i <= NUM_LAMPS; i++) begin
      queue_cmd(1'b0, 4'(i), 24'($urandom));
    end
    queue_cmd(1'b0, 4'(NUM_LAMPS), 24'h000000);
    queue_cmd(1'b1, 4'd7, 24'h800001);
    wait_drained();

    write_reg(REG_SRC_ADDR, 8'h00);
    write_reg(REG_CTRL_ADDR, 8'hFF);
    @(negedge clk);
    queue_random(35);
    wait_drained();

    write_reg(REG_SRC_ADDR, 8'hFF);
    write_reg(REG_CTRL_ADDR, 8'h00);
    @(negedge clk);
    queue_random(35);
    wait_drained();

    // The closing stretch runs with no random gaps: commands are sent back to back and out_tready stays high.
    write_reg(REG_SRC_ADDR, 8'($urandom));
    write_reg(REG_CTRL_ADDR, 8'($urandom));
    @(negedge clk);
    quiet = 1'b1;
    queue_random(35);
    wait_drained();

    if (errors == 0 && frame_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
